FILE: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Stepper controller package
// Shared types and constants for the step/direction stepper controller.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

   localparam int VALUE_W     = 32;
   localparam int PERIOD_IN_W = 24;
   localparam int BACKLASH_W  = 12;
   localparam int STEPS_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   typedef enum logic [2:0] {
      OP_TICK           = 3'd0,
      OP_SET_SPEED      = 3'd1,
      OP_MOVE           = 3'd2,
      OP_RUN_STEPS      = 3'd3,
      OP_ROTATE         = 3'd4,
      OP_RESUME         = 3'd5,
      OP_RESET_POSITION = 3'd6
   } op_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_RELATIVE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_POWER       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT_DIRECTION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKLASH_STEPS   = 2'd3;

   typedef struct packed {
      logic                          relative_mode;
      logic                          auto_power;
      logic                          invert_direction;
      logic signed [BACKLASH_W-1:0]  backlash_steps;
   } cfg_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [VALUE_W-1:0]     value;
      logic [PERIOD_IN_W-1:0]        period_ticks;
      logic                          direction;
   } item_type;

   typedef struct packed {
      logic                          step_pulse;
      logic                          direction_pin;
      logic                          enable_n;
      logic                          busy_res;
      logic                          done_res;
      logic signed [VALUE_W-1:0]     position;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/stp_cfg.sv
// ----------------------------------------------------------------------------
// Stepper controller configuration registers
// Holds the mode bits and the backlash setting written through the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_cfg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write,
   input  wire logic [stp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [stp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output stp_pkg::cfg_type                       cfg
);

   stp_pkg::cfg_type cfg_ff;
   stp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            stp_pkg::CSR_RELATIVE_MODE:    cfg_in.relative_mode    = csr_wdata[0];
            stp_pkg::CSR_AUTO_POWER:       cfg_in.auto_power       = csr_wdata[0];
            stp_pkg::CSR_INVERT_DIRECTION: cfg_in.invert_direction = csr_wdata[0];
            stp_pkg::CSR_BACKLASH_STEPS:   cfg_in.backlash_steps   =
               csr_wdata[stp_pkg::BACKLASH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hdl/stp_move.sv
// ----------------------------------------------------------------------------
// Stepper controller move planner
// Works out the target, direction and step count of a move command.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_move #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                                   relative_mode,
   input  wire logic signed [stp_pkg::BACKLASH_W-1:0]  backlash_steps,
   input  wire logic signed [stp_pkg::VALUE_W-1:0]     value,
   input  wire logic signed [POSITION_BITS-1:0]        last_commanded,
   input  wire logic signed [POSITION_BITS-1:0]        current_position,
   input  wire logic                                   moving_forward,
   output logic                                        ignore,
   output logic signed [POSITION_BITS-1:0]             target,
   output logic                                        forward_next,
   output logic [stp_pkg::STEPS_W-1:0]                 distance
);

   localparam int VW = (POSITION_BITS > stp_pkg::VALUE_W) ? POSITION_BITS : stp_pkg::VALUE_W;
   localparam int GW = POSITION_BITS + 1;
   localparam int DW = (GW + 1 > stp_pkg::STEPS_W + 1) ? GW + 1 : stp_pkg::STEPS_W + 1;

   logic signed [VW-1:0]            value_ext;
   logic signed [POSITION_BITS-1:0] rel_target;
   logic signed [GW-1:0]            goal_raw;
   logic signed [GW-1:0]            goal;
   logic signed [DW-1:0]            diff;
   logic [DW-1:0]                   magnitude;

   assign value_ext  = VW'(value);
   assign rel_target = last_commanded + value_ext[POSITION_BITS-1:0];
   assign ignore     = relative_mode && (value == '0);
   assign target     = relative_mode ? rel_target : value_ext[POSITION_BITS-1:0];

   always_comb begin
      if (target > last_commanded) begin
         forward_next = 1'b1;
      end else if (target < last_commanded) begin
         forward_next = 1'b0;
      end else begin
         forward_next = moving_forward;
      end
   end

   // The goal saturates at the signed range of the position, but only when POSITION_BITS is 64 or more.
   always_comb begin
      goal_raw = forward_next ? GW'(target) + GW'(backlash_steps) : GW'(target);
      goal     = goal_raw;
      if ((GW > 64) && (goal_raw[GW-1] != goal_raw[GW-2])) begin
         goal = {{2{goal_raw[GW-1]}}, {(GW-2){~goal_raw[GW-1]}}};
      end
   end

   assign diff      = DW'(goal) - DW'(current_position);
   assign magnitude = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign distance  = (magnitude[DW-1:stp_pkg::STEPS_W] != '0) ? '1
                                                               : magnitude[stp_pkg::STEPS_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/stp_core.sv
// ----------------------------------------------------------------------------
// Stepper controller motion core
// Holds the motion state and applies one tick or command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_core #(
   parameter int POSITION_BITS = 32,
   parameter int PERIOD_BITS   = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  stp_pkg::item_type         item,
   input  stp_pkg::cfg_type          cfg,
   output stp_pkg::result_type       result
);

   localparam int PW = (PERIOD_BITS > stp_pkg::PERIOD_IN_W) ? PERIOD_BITS : stp_pkg::PERIOD_IN_W;
   localparam int OW = (POSITION_BITS > stp_pkg::VALUE_W) ? POSITION_BITS : stp_pkg::VALUE_W;
   localparam int VW_POS = OW;

   logic signed [POSITION_BITS-1:0] current_position_ff, current_position_in;
   logic signed [POSITION_BITS-1:0] last_commanded_ff, last_commanded_in;
   logic [stp_pkg::STEPS_W-1:0]     remaining_steps_ff, remaining_steps_in;
   logic [PERIOD_BITS-1:0]          step_period_ff, step_period_in;
   logic [PERIOD_BITS-1:0]          elapsed_ticks_ff, elapsed_ticks_in;
   logic                            moving_forward_ff, moving_forward_in;
   logic                            ready_flag_ff, ready_flag_in;
   logic                            stopped_flag_ff, stopped_flag_in;
   logic                            driver_enabled_ff, driver_enabled_in;

   logic [PW-1:0]                   period_wide;
   logic [PERIOD_BITS-1:0]          period;
   logic [PERIOD_BITS-1:0]          elapsed_next;
   logic signed [VW_POS-1:0]        value_ext;
   logic signed [OW-1:0]            position_wide;
   logic                            stepped;
   logic                            busy;

   logic                            move_ignore;
   logic signed [POSITION_BITS-1:0] move_target;
   logic                            move_forward;
   logic [stp_pkg::STEPS_W-1:0]     move_distance;

   stp_move #(
      .POSITION_BITS (POSITION_BITS)
   ) u_move (
      .relative_mode    (cfg.relative_mode),
      .backlash_steps   (cfg.backlash_steps),
      .value            (item.value),
      .last_commanded   (last_commanded_ff),
      .current_position (current_position_ff),
      .moving_forward   (moving_forward_ff),
      .ignore           (move_ignore),
      .target           (move_target),
      .forward_next     (move_forward),
      .distance         (move_distance)
   );

   assign period_wide  = PW'(item.period_ticks);
   assign period       = period_wide[PERIOD_BITS-1:0];
   assign value_ext    = VW_POS'(item.value);
   assign elapsed_next = (elapsed_ticks_ff == {PERIOD_BITS{1'b1}})
                         ? elapsed_ticks_ff : elapsed_ticks_ff + PERIOD_BITS'(1);

   always_comb begin
      current_position_in = current_position_ff;
      last_commanded_in   = last_commanded_ff;
      remaining_steps_in  = remaining_steps_ff;
      step_period_in      = step_period_ff;
      elapsed_ticks_in    = elapsed_ticks_ff;
      moving_forward_in   = moving_forward_ff;
      ready_flag_in       = ready_flag_ff;
      stopped_flag_in     = stopped_flag_ff;
      driver_enabled_in   = driver_enabled_ff;
      stepped             = 1'b0;
      busy                = 1'b0;
      case (item.operation)
         stp_pkg::OP_TICK: begin
            elapsed_ticks_in = elapsed_next;
            busy = !(ready_flag_ff || stopped_flag_ff);
            if (busy && (elapsed_next >= step_period_ff)) begin
               stepped          = 1'b1;
               elapsed_ticks_in = '0;
               if (cfg.auto_power) begin
                  driver_enabled_in = 1'b1;
               end
               current_position_in = current_position_ff +
                  (moving_forward_ff ? POSITION_BITS'(1) : {POSITION_BITS{1'b1}});
               if (remaining_steps_ff != '0) begin
                  remaining_steps_in = remaining_steps_ff - stp_pkg::STEPS_W'(1);
                  if (remaining_steps_ff == stp_pkg::STEPS_W'(1)) begin
                     ready_flag_in = 1'b1;
                     if (cfg.auto_power) begin
                        driver_enabled_in = 1'b0;
                     end
                  end
               end
            end
         end
         stp_pkg::OP_SET_SPEED: begin
            if (period == '0) begin
               stopped_flag_in = 1'b1;
               if (cfg.auto_power) begin
                  driver_enabled_in = 1'b0;
               end
            end else begin
               moving_forward_in = item.direction;
               step_period_in    = period;
               stopped_flag_in   = 1'b0;
               if (cfg.auto_power && !ready_flag_ff) begin
                  driver_enabled_in = 1'b1;
               end
            end
         end
         stp_pkg::OP_MOVE: begin
            if (!move_ignore) begin
               last_commanded_in  = move_target;
               moving_forward_in  = move_forward;
               remaining_steps_in = move_distance;
               if (move_distance != '0) begin
                  ready_flag_in = 1'b0;
               end
            end
         end
         stp_pkg::OP_RUN_STEPS: begin
            remaining_steps_in = item.value;
            ready_flag_in      = 1'b0;
         end
         stp_pkg::OP_ROTATE: begin
            moving_forward_in = item.direction;
            ready_flag_in     = 1'b0;
         end
         stp_pkg::OP_RESUME: begin
            ready_flag_in = 1'b0;
         end
         stp_pkg::OP_RESET_POSITION: begin
            current_position_in = value_ext[POSITION_BITS-1:0];
            remaining_steps_in  = '0;
            ready_flag_in       = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_position_ff <= '0;
         last_commanded_ff   <= '0;
         remaining_steps_ff  <= '0;
         step_period_ff      <= '0;
         elapsed_ticks_ff    <= '0;
         moving_forward_ff   <= 1'b1;
         ready_flag_ff       <= 1'b1;
         stopped_flag_ff     <= 1'b0;
         driver_enabled_ff   <= 1'b0;
      end else if (advance) begin
         current_position_ff <= current_position_in;
         last_commanded_ff   <= last_commanded_in;
         remaining_steps_ff  <= remaining_steps_in;
         step_period_ff      <= step_period_in;
         elapsed_ticks_ff    <= elapsed_ticks_in;
         moving_forward_ff   <= moving_forward_in;
         ready_flag_ff       <= ready_flag_in;
         stopped_flag_ff     <= stopped_flag_in;
         driver_enabled_ff   <= driver_enabled_in;
      end
   end

   assign position_wide        = OW'(current_position_in);
   assign result.step_pulse    = stepped;
   assign result.direction_pin = moving_forward_in ^ cfg.invert_direction;
   assign result.enable_n      = !driver_enabled_in;
   assign result.busy_res      = busy;
   assign result.done_res      = ready_flag_in;
   assign result.position      = position_wide[stp_pkg::VALUE_W-1:0];

   a_step_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      stepped |-> (item.operation == stp_pkg::OP_TICK))
      else $error("step issued by a command beat");

   a_step_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      (advance && stepped) |=> (elapsed_ticks_ff == '0))
      else $error("elapsed counter not cleared after a step");

   a_last_step_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (advance && stepped && (remaining_steps_ff == stp_pkg::STEPS_W'(1))) |=> ready_flag_ff)
      else $error("counted move finished without setting ready");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(current_position_ff) && $stable(remaining_steps_ff)
                    && $stable(ready_flag_ff)))
      else $error("motion state changed without a beat");

endmodule

`default_nettype wire

FILE: hdl/stepper_step_dir_controller.sv
// ----------------------------------------------------------------------------
// Step/direction stepper controller
// Turns a stream of microsecond ticks and motion commands into step,
// direction and driver enable outputs with position tracking.
// ----------------------------------------------------------------------------
// Each beat on the request channel is one tick or one command and yields
// exactly one response beat. The controller takes a new beat every clock
// while the response channel is not stalled. Each response passes through
// the input register and then the result register, with the whole state
// update done in a single pass between them. Configuration should be written
// only while no beat is in flight.
`default_nettype none

module stepper_step_dir_controller #(
   parameter int POSITION_BITS = 32,
   parameter int PERIOD_BITS   = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write,
   input  wire logic [stp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [stp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [2:0]                            req_operation,
   input  wire logic signed [stp_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [stp_pkg::PERIOD_IN_W-1:0]       req_period_ticks,
   input  wire logic                                  req_direction,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_step_pulse,
   output logic                                       rsp_direction_pin,
   output logic                                       rsp_enable_n,
   output logic                                       rsp_busy_res,
   output logic                                       rsp_done_res,
   output logic signed [stp_pkg::VALUE_W-1:0]         rsp_position
);

   stp_pkg::cfg_type    cfg;
   stp_pkg::item_type   item_ff;
   stp_pkg::result_type result;
   stp_pkg::result_type rsp_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                out_hold;
   logic                advance;

   stp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_hold  = rsp_valid_ff && rsp_stall;
   assign req_stall = item_valid_ff && out_hold;
   assign advance   = item_valid_ff && !out_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.operation    <= stp_pkg::op_type'(req_operation);
         item_ff.value        <= req_value;
         item_ff.period_ticks <= req_period_ticks;
         item_ff.direction    <= req_direction;
      end
   end

   stp_core #(
      .POSITION_BITS (POSITION_BITS),
      .PERIOD_BITS   (PERIOD_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_hold) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_pulse    = rsp_ff.step_pulse;
   assign rsp_direction_pin = rsp_ff.direction_pin;
   assign rsp_enable_n      = rsp_ff.enable_n;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_position      = rsp_ff.position;

endmodule

`default_nettype wire
